// ----- hw/rtl/sft_pkg.sv -----
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types and constants of the serial frame transmitter.
// ----------------------------------------------------------------------------
package sft_pkg;

  localparam int FRAME_BITS_DEF = 11;
  localparam int DATA_W         = 8;
  localparam int PERIOD_W       = 16;
  localparam int CFG_IDX_W      = 1;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST  = 16'd533;
  localparam logic                PARITY_MODE_RST = 1'b0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_MODE = 1'b1;

  // Item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic line;
    logic busy_res;
    logic rejected;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] bit_period;
    logic                parity_mode;
  } cfg_t;

endpackage

// ----- hw/rtl/sft_cfg.sv -----
// ----------------------------------------------------------------------------
// sft_cfg
// Configuration register file: bit period and parity mode.
// ----------------------------------------------------------------------------
module sft_cfg
  import sft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_wdata,
  output cfg_t                 cfg
);

  logic [PERIOD_W-1:0] bit_period_r;
  logic [PERIOD_W-1:0] bit_period_nxt;
  logic                parity_mode_r;
  logic                parity_mode_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    bit_period_nxt  = bit_period_r;
    parity_mode_nxt = parity_mode_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BIT_PERIOD:  bit_period_nxt  = cfg_wdata;
        REG_PARITY_MODE: parity_mode_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= BIT_PERIOD_RST;
      parity_mode_r <= PARITY_MODE_RST;
    end else begin
      bit_period_r  <= bit_period_nxt;
      parity_mode_r <= parity_mode_nxt;
    end
  end

  assign cfg.bit_period  = bit_period_r;
  assign cfg.parity_mode = parity_mode_r;

endmodule

// ----- hw/rtl/sft_core.sv -----
// ----------------------------------------------------------------------------
// sft_core
// Frame state and per-item update: load, bit timing, shift and flags.
// ----------------------------------------------------------------------------
module sft_core
  import sft_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  localparam int CNT_W  = $clog2(FRAME_BITS + 1);
  localparam int STOP_W = FRAME_BITS - DATA_W - 1;

  logic [FRAME_BITS-1:0] frame_shift_r, frame_shift_nxt;
  logic [CNT_W-1:0]      bits_left_r,   bits_left_nxt;
  logic [PERIOD_W-1:0]   tick_count_r,  tick_count_nxt;
  logic                  line_level_r,  line_level_nxt;

  logic [PERIOD_W-1:0]   period;
  logic [PERIOD_W-1:0]   tick_inc;
  logic [DATA_W-1:0]     tx_byte;
  logic [FRAME_BITS-1:0] frame_new;
  logic [FRAME_BITS-1:0] frame_sh;
  logic [CNT_W-1:0]      bits_dec;
  logic                  busy;
  logic                  rejected;
  logic                  done;

  assign busy     = (bits_left_r != '0);
  assign period   = (cfg.bit_period == '0) ? PERIOD_W'(1) : cfg.bit_period;
  assign tick_inc = tick_count_r + PERIOD_W'(1);
  assign frame_sh = frame_shift_r >> 1;
  assign bits_dec = bits_left_r - CNT_W'(1);

  always_comb begin
    tx_byte = item.data;
    if (cfg.parity_mode) begin
      tx_byte[DATA_W-1] = item.data[DATA_W-1] | (^item.data);
    end
    frame_new = {{STOP_W{1'b0}}, tx_byte, 1'b1};
  end

  always_comb begin
    frame_shift_nxt = frame_shift_r;
    bits_left_nxt   = bits_left_r;
    tick_count_nxt  = tick_count_r;
    line_level_nxt  = line_level_r;
    rejected        = 1'b0;
    done            = 1'b0;
    if (item.cmd == CMD_LOAD) begin
      if (busy) begin
        rejected = 1'b1;
      end else begin
        frame_shift_nxt = frame_new;
        bits_left_nxt   = CNT_W'(FRAME_BITS);
        tick_count_nxt  = '0;
        line_level_nxt  = frame_new[0];
      end
    end else if (busy) begin
      tick_count_nxt = tick_inc;
      if (tick_inc >= period) begin
        tick_count_nxt = '0;
        bits_left_nxt  = bits_dec;
        if (bits_dec == '0) begin
          done            = 1'b1;
          line_level_nxt  = 1'b0;
          frame_shift_nxt = '0;
        end else begin
          frame_shift_nxt = frame_sh;
          line_level_nxt  = frame_sh[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_shift_r <= '0;
      bits_left_r   <= '0;
      tick_count_r  <= '0;
      line_level_r  <= 1'b0;
    end else if (accept) begin
      frame_shift_r <= frame_shift_nxt;
      bits_left_r   <= bits_left_nxt;
      tick_count_r  <= tick_count_nxt;
      line_level_r  <= line_level_nxt;
    end
  end

  assign result.line       = line_level_nxt;
  assign result.busy_res   = (bits_left_nxt != '0);
  assign result.rejected   = rejected;
  assign result.frame_done = done;

endmodule

// ----- hw/rtl/sft_out_stage.sv -----
// ----------------------------------------------------------------------------
// sft_out_stage
// Result register with valid/stall handshake; refills while being drained.
// ----------------------------------------------------------------------------
module sft_out_stage
  import sft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full_stalled,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  assign full_stalled = valid_r && out_stall;

  always_comb begin
    priority if (push) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = data_r;

endmodule

// ----- hw/rtl/serial_frame_transmitter_top.sv -----
// ----------------------------------------------------------------------------
// serial_frame_transmitter_top
// Bit-timed serial frame transmitter: start high, 8 data bits, stop bits low.
//
//   port group  direction  handshake            payload
//   in_         input      in_valid / in_stall  in_item  (cmd, data)
//   out_        output     out_valid / out_stall out_item (line, busy_res,
//                                                rejected, frame_done)
//   cfg_        input      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// One item per clock unless in_stall; each result is in the output register
// in the cycle after its transfer. in_stall is high only while a result waits
// under out_stall. Reset is synchronous and clears frame state and config to
// defaults (bit period 533, parity off). Config writes complete every cycle.
// ----------------------------------------------------------------------------
module serial_frame_transmitter_top
  import sft_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_wdata
);

  cfg_t      cfg;
  out_item_t result;
  logic      accept;

  assign accept = in_valid && !in_stall;

  sft_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sft_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  sft_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (accept),
    .push_data    (result),
    .full_stalled (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

endmodule

// ----- hw/rtl/sft_checker.sv -----
// ----------------------------------------------------------------------------
// sft_checker
// Port-level checks of the serial frame transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module sft_checker
  import sft_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input out_item_t out_item,
  input logic      out_valid,
  input logic      out_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("transfer gave no result in the next cycle");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no waiting result");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.rejected |-> out_item.busy_res && !out_item.frame_done)
    else $error("reject flagged while idle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_done |-> !out_item.busy_res && !out_item.line)
    else $error("frame end with line high or still busy");

endmodule

bind serial_frame_transmitter_top sft_checker u_sft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_item  (out_item),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
